// ===== hdl/hpt_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the compensation block.
`timescale 1ns / 1ps
package hpt_pkg;

   localparam int DIV_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CALIB = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_LOW = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_MID = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_HIGH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUMID_LOW = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUMID_HIGH = 3'd5;

   localparam logic [31:0] HUM_MAX_Q = 32'd419430400;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic [31:0] hum_x;
      logic big;
      logic ok;
   } hpt_side_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      logic signed [31:0] s;
      s = $signed(x);
      return 32'(s >>> n);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return p[31:0];
   endfunction

endpackage

// ===== hdl/humidity_pressure_temp_compensation.sv =====
// Top level: pipelined temperature, pressure and humidity compensation.
// Pipeline: 9 front stages, 32 divider stages and 3 back stages between an accepted
// request and its response.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// response waits. Synchronous active-high reset clears valids and calibration.
`timescale 1ns / 1ps
module humidity_pressure_temp_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_temp_centideg,
   output logic signed [31:0] rsp_fine_temp,
   output logic [31:0] rsp_pressure_pa,
   output logic        rsp_pressure_valid,
   output logic [16:0] rsp_humidity_q22_10,
   input  logic        csr_we,
   input  logic [hpt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hpt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hpt_pkg::*;

   logic [47:0] tcal_ff, plo_ff, pmid_ff, phi_ff;
   logic [31:0] hlo_ff, hhi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff <= '0; plo_ff <= '0; pmid_ff <= '0; phi_ff <= '0;
         hlo_ff <= '0; hhi_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_CALIB: tcal_ff <= csr_wdata;
            CSR_PRESS_LOW: plo_ff <= csr_wdata;
            CSR_PRESS_MID: pmid_ff <= csr_wdata;
            CSR_PRESS_HIGH: phi_ff <= csr_wdata;
            CSR_HUMID_LOW: hlo_ff <= csr_wdata[31:0];
            CSR_HUMID_HIGH: hhi_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
   assign t1 = {16'd0, tcal_ff[15:0]};
   assign t2 = {{16{tcal_ff[31]}}, tcal_ff[31:16]};
   assign t3 = {{16{tcal_ff[47]}}, tcal_ff[47:32]};
   assign p1 = {16'd0, plo_ff[15:0]};
   assign p2 = {{16{plo_ff[31]}}, plo_ff[31:16]};
   assign p3 = {{16{plo_ff[47]}}, plo_ff[47:32]};
   assign p4 = {{16{pmid_ff[15]}}, pmid_ff[15:0]};
   assign p5 = {{16{pmid_ff[31]}}, pmid_ff[31:16]};
   assign p6 = {{16{pmid_ff[47]}}, pmid_ff[47:32]};
   assign p7 = {{16{phi_ff[15]}}, phi_ff[15:0]};
   assign p8 = {{16{phi_ff[31]}}, phi_ff[31:16]};
   assign p9 = {{16{phi_ff[47]}}, phi_ff[47:32]};
   assign h1 = {24'd0, hlo_ff[7:0]};
   assign h2 = {{16{hlo_ff[23]}}, hlo_ff[23:8]};
   assign h3 = {24'd0, hlo_ff[31:24]};
   assign h4 = {{20{hhi_ff[11]}}, hhi_ff[11:0]};
   assign h5 = {{20{hhi_ff[23]}}, hhi_ff[23:12]};
   assign h6 = {{24{hhi_ff[31]}}, hhi_ff[31:24]};

   logic en;
   logic [9:1] v_ff;
   logic [2:0] pv_ff;
   logic div_vld;
   logic [31:0] div_quo;
   hpt_side_type div_side, side_in;
   logic [31:0] div_num_in;

   assign en = !(pv_ff[2] && !rsp_ready);
   assign req_ready = en;

   // front stage registers and next values
   logic [31:0] s1_ma_ff, s1_dd_ff, s1_ma_in, s1_dd_in;
   logic [19:0] s1_p_ff, s2_p_ff, s3_p_ff, s4_p_ff, s5_p_ff, s6_p_ff, s7_p_ff;
   logic [15:0] s1_h_ff, s2_h_ff, s3_h_ff, s4_h_ff, s5_h_ff;
   logic [31:0] s2_a_ff, s2_b_ff, s2_a_in, s2_b_in;
   logic [31:0] s3_tf_ff, s3_tf_in;
   logic [31:0] s4_tm_ff, s4_a0_ff, s4_q_ff, s4_x_ff, s4_tf_ff;
   logic [31:0] s4_tm_in, s4_a0_in, s4_q_in, s4_x_in;
   logic [31:0] s5_temp_ff, s5_qq_ff, s5_ap5_ff, s5_ap2_ff, s5_xh6_ff, s5_xh3_ff, s5_h5x_ff;
   logic [31:0] s5_temp_in, s5_qq_in, s5_ap5_in, s5_ap2_in, s5_xh6_in, s5_xh3_in, s5_h5x_in;
   logic [31:0] s5_tf_ff;
   logic [31:0] s6_b_ff, s6_c_ff, s6_u_ff, s6_v1_ff, s6_v2_ff, s6_ap5_ff, s6_ap2_ff;
   logic [31:0] s6_b_in, s6_c_in, s6_u_in, s6_v1_in, s6_v2_in;
   logic [31:0] s6_temp_ff, s6_tf_ff;
   logic [31:0] s7_b2_ff, s7_a2_ff, s7_vv_ff, s7_u_ff, s7_temp_ff, s7_tf_ff;
   logic [31:0] s7_b2_in, s7_a2_in, s7_vv_in;
   logic [31:0] s8_a3_ff, s8_pn_ff, s8_vw_ff, s8_u_ff, s8_temp_ff, s8_tf_ff;
   logic [31:0] s8_a3_in, s8_pn_in, s8_vw_in;
   logic [31:0] s9_da_ff, s9_pm_ff, s9_vh_ff, s9_u_ff, s9_temp_ff, s9_tf_ff;
   logic [31:0] s9_da_in, s9_pm_in, s9_vh_in;

   always_comb begin
      s1_ma_in = mul32(32'({12'd0, req_raw_temperature} >> 3) - (t1 << 1), t2);
      s1_dd_in = mul32(32'({12'd0, req_raw_temperature} >> 4) - t1,
                       32'({12'd0, req_raw_temperature} >> 4) - t1);
      s2_a_in = asr(s1_ma_ff, 11);
      s2_b_in = mul32(asr(s1_dd_ff, 12), t3);
      s3_tf_in = s2_a_ff + asr(s2_b_ff, 14);
      s4_tm_in = mul32(s3_tf_ff, 32'd5) + 32'd128;
      s4_a0_in = asr(s3_tf_ff, 1) - 32'd64000;
      s4_q_in = asr(s4_a0_in, 2);
      s4_x_in = s3_tf_ff - 32'd76800;
      s5_temp_in = asr(s4_tm_ff, 8);
      s5_qq_in = mul32(s4_q_ff, s4_q_ff);
      s5_ap5_in = mul32(s4_a0_ff, p5);
      s5_ap2_in = mul32(p2, s4_a0_ff);
      s5_xh6_in = mul32(s4_x_ff, h6);
      s5_xh3_in = mul32(s4_x_ff, h3);
      s5_h5x_in = mul32(h5, s4_x_ff);
      s6_b_in = mul32(asr(s5_qq_ff, 11), p6);
      s6_c_in = mul32(p3, asr(s5_qq_ff, 13));
      s6_u_in = asr(({16'd0, s5_h_ff} << 14) - (h4 << 20) - s5_h5x_ff + 32'd16384, 15);
      s6_v1_in = asr(s5_xh6_ff, 10);
      s6_v2_in = asr(s5_xh3_ff, 11) + 32'd32768;
      s7_b2_in = asr(s6_b_ff + (s6_ap5_ff << 1), 2) + (p4 << 16);
      s7_a2_in = asr(asr(s6_c_ff, 3) + asr(s6_ap2_ff, 1), 18);
      s7_vv_in = mul32(s6_v1_ff, s6_v2_ff);
      s8_a3_in = mul32(32'd32768 + s7_a2_ff, p1);
      s8_pn_in = (32'd1048576 - {12'd0, s7_p_ff}) - asr(s7_b2_ff, 12);
      s8_vw_in = asr(s7_vv_ff, 10) + 32'd2097152;
      s9_da_in = asr(s8_a3_ff, 15);
      s9_pm_in = mul32(s8_pn_ff, 32'd3125);
      s9_vh_in = mul32(s8_vw_ff, h2) + 32'd8192;
      div_num_in = s9_pm_ff[31] ? s9_pm_ff : (s9_pm_ff << 1);
      side_in.temp = s9_temp_ff;
      side_in.fine = s9_tf_ff;
      side_in.hum_x = mul32(s9_u_ff, asr(s9_vh_ff, 14));
      side_in.big = s9_pm_ff[31];
      side_in.ok = (s9_da_ff != 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[8:1], req_valid};
      end
      if (en) begin
         s1_ma_ff <= s1_ma_in; s1_dd_ff <= s1_dd_in;
         s1_p_ff <= req_raw_pressure; s1_h_ff <= req_raw_humidity;
         s2_a_ff <= s2_a_in; s2_b_ff <= s2_b_in; s2_p_ff <= s1_p_ff; s2_h_ff <= s1_h_ff;
         s3_tf_ff <= s3_tf_in; s3_p_ff <= s2_p_ff; s3_h_ff <= s2_h_ff;
         s4_tm_ff <= s4_tm_in; s4_a0_ff <= s4_a0_in; s4_q_ff <= s4_q_in;
         s4_x_ff <= s4_x_in; s4_tf_ff <= s3_tf_ff; s4_p_ff <= s3_p_ff; s4_h_ff <= s3_h_ff;
         s5_temp_ff <= s5_temp_in; s5_qq_ff <= s5_qq_in; s5_ap5_ff <= s5_ap5_in;
         s5_ap2_ff <= s5_ap2_in; s5_xh6_ff <= s5_xh6_in; s5_xh3_ff <= s5_xh3_in;
         s5_h5x_ff <= s5_h5x_in; s5_tf_ff <= s4_tf_ff; s5_p_ff <= s4_p_ff;
         s5_h_ff <= s4_h_ff;
         s6_b_ff <= s6_b_in; s6_c_ff <= s6_c_in; s6_u_ff <= s6_u_in;
         s6_v1_ff <= s6_v1_in; s6_v2_ff <= s6_v2_in; s6_ap5_ff <= s5_ap5_ff;
         s6_ap2_ff <= s5_ap2_ff; s6_temp_ff <= s5_temp_ff; s6_tf_ff <= s5_tf_ff;
         s6_p_ff <= s5_p_ff;
         s7_b2_ff <= s7_b2_in; s7_a2_ff <= s7_a2_in; s7_vv_ff <= s7_vv_in;
         s7_u_ff <= s6_u_ff; s7_temp_ff <= s6_temp_ff; s7_tf_ff <= s6_tf_ff;
         s7_p_ff <= s6_p_ff;
         s8_a3_ff <= s8_a3_in; s8_pn_ff <= s8_pn_in; s8_vw_ff <= s8_vw_in;
         s8_u_ff <= s7_u_ff; s8_temp_ff <= s7_temp_ff; s8_tf_ff <= s7_tf_ff;
         s9_da_ff <= s9_da_in; s9_pm_ff <= s9_pm_in; s9_vh_ff <= s9_vh_in;
         s9_u_ff <= s8_u_ff; s9_temp_ff <= s8_temp_ff; s9_tf_ff <= s8_tf_ff;
      end
   end

   hpt_div u_div (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(v_ff[9]),
      .in_num(div_num_in),
      .in_den(s9_da_ff),
      .in_side(side_in),
      .out_valid(div_vld),
      .out_quo(div_quo),
      .out_side(div_side)
   );

   // back stages
   logic [31:0] b1_p_ff, b1_qq_ff, b1_pp_ff, b1_pv_ff;
   logic [31:0] b1_p_in, b1_qq_in, b1_pp_in, b1_pv_in;
   hpt_side_type b1_side_ff, b2_side_ff;
   logic [31:0] b2_p_ff, b2_hm_ff, b2_u_ff, b2_v_ff;
   logic [31:0] b2_hm_in, b2_u_in, b2_v_in;
   logic [31:0] out_pa_ff, out_pa_in, out_temp_ff, out_tf_ff;
   logic out_ok_ff;
   logic [16:0] out_hum_ff, out_hum_in;

   always_comb begin
      logic [31:0] hx;
      b1_p_in = div_side.big ? (div_quo << 1) : div_quo;
      b1_qq_in = mul32(asr(div_side.hum_x, 15), asr(div_side.hum_x, 15));
      b1_pp_in = mul32(b1_p_in >> 3, b1_p_in >> 3);
      b1_pv_in = mul32(b1_p_in >> 2, p8);
      b2_hm_in = mul32(asr(b1_qq_ff, 7), h1);
      b2_u_in = asr(mul32(p9, b1_pp_ff >> 13), 12);
      b2_v_in = asr(b1_pv_ff, 13);
      out_pa_in = b2_side_ff.ok ? (b2_p_ff + asr(b2_u_ff + b2_v_ff + p7, 4)) : 32'd0;
      hx = b2_side_ff.hum_x - asr(b2_hm_ff, 4);
      if (hx[31]) begin
         hx = 32'd0;
      end else if (hx > HUM_MAX_Q) begin
         hx = HUM_MAX_Q;
      end
      out_hum_in = hx[28:12];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[1:0], div_vld};
      end
      if (en) begin
         b1_p_ff <= b1_p_in; b1_qq_ff <= b1_qq_in; b1_pp_ff <= b1_pp_in;
         b1_pv_ff <= b1_pv_in; b1_side_ff <= div_side;
         b2_p_ff <= b1_p_ff; b2_hm_ff <= b2_hm_in; b2_u_ff <= b2_u_in;
         b2_v_ff <= b2_v_in; b2_side_ff <= b1_side_ff;
         out_pa_ff <= out_pa_in; out_hum_ff <= out_hum_in;
         out_temp_ff <= b2_side_ff.temp; out_tf_ff <= b2_side_ff.fine;
         out_ok_ff <= b2_side_ff.ok;
      end
   end

   assign rsp_valid = pv_ff[2];
   assign rsp_temp_centideg = $signed(out_temp_ff);
   assign rsp_fine_temp = $signed(out_tf_ff);
   assign rsp_pressure_pa = out_pa_ff;
   assign rsp_pressure_valid = out_ok_ff;
   assign rsp_humidity_q22_10 = out_hum_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pressure_valid |-> rsp_pressure_pa == 32'd0)
      else $error("invalid pressure not zero");
   a_hum_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q22_10 <= 17'd102400)
      else $error("humidity above clamp");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken during output stall");

endmodule

// ===== hdl/hpt_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module hpt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [hpt_pkg::DIV_W-1:0] in_num,
   input  logic [hpt_pkg::DIV_W-1:0] in_den,
   input  hpt_pkg::hpt_side_type in_side,
   output logic                  out_valid,
   output logic [hpt_pkg::DIV_W-1:0] out_quo,
   output hpt_pkg::hpt_side_type out_side
);
   import hpt_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] nq_ff [DIV_W];
   logic [DIV_W-1:0] den_ff [DIV_W];
   hpt_side_type side_ff [DIV_W];
   logic [DIV_W-1:0] vld_ff;

   logic [DIV_W-1:0] rem_in [DIV_W];
   logic [DIV_W-1:0] nq_in [DIV_W];

   always_comb begin
      logic [DIV_W-1:0] r;
      logic [DIV_W-1:0] n;
      logic [DIV_W-1:0] d;
      logic [DIV_W:0] t;
      for (int s = 0; s < DIV_W; s++) begin
         if (s == 0) begin
            r = '0;
            n = in_num;
            d = in_den;
         end else begin
            r = rem_ff[s-1];
            n = nq_ff[s-1];
            d = den_ff[s-1];
         end
         t = {r, n[DIV_W-1]};
         if (t >= {1'b0, d}) begin
            rem_in[s] = DIV_W'(t - {1'b0, d});
            nq_in[s] = {n[DIV_W-2:0], 1'b1};
         end else begin
            rem_in[s] = t[DIV_W-1:0];
            nq_in[s] = {n[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_W-2:0], in_valid};
      end
      if (en) begin
         den_ff[0] <= in_den;
         side_ff[0] <= in_side;
         for (int s = 0; s < DIV_W; s++) begin
            rem_ff[s] <= rem_in[s];
            nq_ff[s] <= nq_in[s];
         end
         for (int s = 1; s < DIV_W; s++) begin
            den_ff[s] <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[DIV_W-1];
   assign out_quo = nq_ff[DIV_W-1];
   assign out_side = side_ff[DIV_W-1];

endmodule
